/* rtl/latency_statistics_monitor_defines.svh */
// ----------------------------------------------------------------------------
// Latency statistics monitor: assertion macros
// Shared assertion forms for the monitor's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef LATENCY_STATISTICS_MONITOR_DEFINES_SVH
`define LATENCY_STATISTICS_MONITOR_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define LSM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define LSM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lsm_pkg.sv */
// ----------------------------------------------------------------------------
// Latency statistics monitor package
// Shared constants, types and the percentile index function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lsm_pkg;

  localparam int Window  = 128;
  localparam int WinIdxW = (Window > 1) ? $clog2(Window) : 1;
  localparam int FillW   = $clog2(Window + 1);

  localparam logic [1:0] CMD_RECORD = 2'd0;
  localparam logic [1:0] CMD_REPORT = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [6:0] PCT_95 = 7'd95;
  localparam logic [6:0] PCT_99 = 7'd99;

  // floor(x / 100) as (x * RecipM) >> RecipK, exact for the index range
  localparam int          RecipK = 24;
  localparam logic [17:0] RecipM = 18'd167773;
  localparam int          ProdW  = FillW + 7;
  localparam int          MulW   = ProdW + 18;

  typedef enum logic [1:0] {
    KIND_RECORD,
    KIND_REPORT,
    KIND_CLEAR,
    KIND_NOP
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] latency;
  } item_t;

  typedef struct packed {
    logic             busy;
    logic [FillW-1:0] fill;
  } back_status_t;

  function automatic logic [FillW-1:0] pct_index(input logic [FillW-1:0] n,
                                                 input logic [6:0]       pct);
    logic [ProdW-1:0] prod;
    logic [MulW-1:0]  scaled;
    prod   = ProdW'(n) * ProdW'(pct);
    scaled = MulW'(prod) * MulW'(RecipM);
    return scaled[RecipK +: FillW];
  endfunction

endpackage

`default_nettype wire

/* rtl/lsm_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsm_ram #(
  parameter int Width = 32,
  parameter int Depth = 128
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                         wdata_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/lsm_div.sv */
// ----------------------------------------------------------------------------
// Serial divider
// Restoring 64 by 32 bit division, one quotient bit per cycle, saturating.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsm_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output logic             done_o,
  output logic      [31:0] quotient_o
);

  logic        run_q, done_q;
  logic [5:0]  step_q;
  logic [31:0] rem_q, div_q;
  logic [63:0] quo_q;
  logic [32:0] trial;
  logic [33:0] diff;
  logic        ge;

  assign trial = {rem_q, quo_q[63]};
  assign diff  = {1'b0, trial} - {2'b00, div_q};
  assign ge    = ~diff[33];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      rem_q  <= '0;
      div_q  <= '0;
      quo_q  <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
      rem_q  <= '0;
      div_q  <= divisor_i;
      quo_q  <= dividend_i;
    end else if (run_q) begin
      rem_q  <= ge ? diff[31:0] : trial[31:0];
      quo_q  <= {quo_q[62:0], ge};
      step_q <= step_q + 6'd1;
      if (step_q == 6'd63) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  assign done_o     = done_q;
  // clamp a quotient that does not fit 32 bits
  assign quotient_o = (|quo_q[63:32]) ? '1 : quo_q[31:0];

endmodule

`default_nettype wire

/* rtl/lsm_front.sv */
// ----------------------------------------------------------------------------
// Monitor front end
// Accept commands, classify them and hold them in a two-entry queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsm_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  output logic               full_o,
  input  wire logic [1:0]    command_i,
  input  wire logic [31:0]   latency_i,
  output logic               item_valid_o,
  output lsm_pkg::item_t     item_o,
  input  wire logic          item_take_i
);

  lsm_pkg::item_t slot_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  lsm_pkg::item_t incoming;
  logic           wr_en, rd_en;

  always_comb begin
    incoming.latency = latency_i;
    unique case (command_i)
      lsm_pkg::CMD_RECORD: incoming.kind = lsm_pkg::KIND_RECORD;
      lsm_pkg::CMD_REPORT: incoming.kind = lsm_pkg::KIND_REPORT;
      lsm_pkg::CMD_CLEAR:  incoming.kind = lsm_pkg::KIND_CLEAR;
      default:             incoming.kind = lsm_pkg::KIND_NOP;
    endcase
  end

  assign full_o       = (cnt_q == 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = slot_q[rd_ptr_q];
  assign wr_en        = push_i && !full_o;
  assign rd_en        = item_take_i && item_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (rd_en) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_q[wr_ptr_q] <= incoming;
    end
  end

endmodule

`default_nettype wire

/* rtl/lsm_back.sv */
// ----------------------------------------------------------------------------
// Monitor back end
// Execute commands: update statistics and window, build reports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsm_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [31:0]          cfg_wdata_i,
  input  wire logic                 item_valid_i,
  input  wire lsm_pkg::item_t       item_i,
  output logic                      item_take_o,
  input  wire logic                 pop_i,
  output logic                      out_valid_o,
  output logic                      violation_o,
  output logic                      empty_res_o,
  output logic [31:0]               sample_count_o,
  output logic [31:0]               max_latency_o,
  output logic [31:0]               min_latency_o,
  output logic [31:0]               avg_latency_o,
  output logic [31:0]               violation_count_o,
  output logic [31:0]               p95_latency_o,
  output logic [31:0]               p99_latency_o,
  output lsm_pkg::back_status_t     status_o
);

  localparam int FW = lsm_pkg::FillW;
  localparam int IW = lsm_pkg::WinIdxW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAND,
    ST_CLAT,
    ST_SCAN,
    ST_CHECK,
    ST_DIVW
  } state_e;

  state_e         state_q;
  logic [31:0]    thr_q, count_q, max_q, min_q, viol_q;
  logic [63:0]    sum_q;
  logic [FW-1:0]  fill_q, cand_q, scan_q, lt_q, le_q, k95_q, k99_q;
  logic [IW-1:0]  oldest_q;
  logic [31:0]    cand_val_q, p95_q, p99_q;
  logic           pend_q, f95_q, f99_q;
  logic           out_valid_q;

  logic           pop_acc, take;
  logic           ram_we;
  logic [IW-1:0]  waddr, raddr;
  logic [31:0]    rdata;
  logic [FW:0]    slot_sum;
  logic           div_start, div_done;
  logic [31:0]    quotient;
  logic           hit95, hit99;

  assign pop_acc     = pop_i && out_valid_q;
  assign take        = (state_q == ST_IDLE) && item_valid_i && (!out_valid_q || pop_i);
  assign item_take_o = take;
  assign ram_we      = take && (item_i.kind == lsm_pkg::KIND_RECORD);
  assign div_start   = take && (item_i.kind == lsm_pkg::KIND_REPORT) && (count_q != '0);

  // append behind the oldest entry while filling, overwrite the oldest when full
  always_comb begin
    slot_sum = (FW+1)'(oldest_q) + {1'b0, fill_q};
    if (fill_q < FW'(lsm_pkg::Window)) begin
      if (slot_sum >= (FW+1)'(lsm_pkg::Window)) begin
        waddr = IW'(slot_sum - (FW+1)'(lsm_pkg::Window));
      end else begin
        waddr = IW'(slot_sum);
      end
    end else begin
      waddr = oldest_q;
    end
  end

  always_comb begin
    unique case (state_q)
      ST_CAND: raddr = cand_q[IW-1:0];
      ST_SCAN: raddr = scan_q[IW-1:0];
      default: raddr = '0;
    endcase
  end

  assign hit95 = !f95_q && (lt_q <= k95_q) && (k95_q < le_q);
  assign hit99 = !f99_q && (lt_q <= k99_q) && (k99_q < le_q);

  lsm_ram #(
    .Width(32),
    .Depth(lsm_pkg::Window)
  ) u_window (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(waddr),
    .wdata_i(item_i.latency),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  lsm_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(sum_q),
    .divisor_i (count_q),
    .done_o    (div_done),
    .quotient_o(quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= ST_IDLE;
      thr_q             <= 32'd5000;
      count_q           <= '0;
      sum_q             <= '0;
      max_q             <= '0;
      min_q             <= '1;
      viol_q            <= '0;
      fill_q            <= '0;
      oldest_q          <= '0;
      cand_q            <= '0;
      scan_q            <= '0;
      lt_q              <= '0;
      le_q              <= '0;
      k95_q             <= '0;
      k99_q             <= '0;
      cand_val_q        <= '0;
      p95_q             <= '0;
      p99_q             <= '0;
      pend_q            <= 1'b0;
      f95_q             <= 1'b0;
      f99_q             <= 1'b0;
      out_valid_q       <= 1'b0;
      violation_o       <= 1'b0;
      empty_res_o       <= 1'b0;
      sample_count_o    <= '0;
      max_latency_o     <= '0;
      min_latency_o     <= '0;
      avg_latency_o     <= '0;
      violation_count_o <= '0;
      p95_latency_o     <= '0;
      p99_latency_o     <= '0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (pop_acc && !take) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (take) begin
            violation_o       <= (item_i.kind == lsm_pkg::KIND_RECORD) &&
                                 (item_i.latency > thr_q);
            empty_res_o       <= (item_i.kind == lsm_pkg::KIND_REPORT) && (count_q == '0);
            sample_count_o    <= '0;
            max_latency_o     <= '0;
            min_latency_o     <= '0;
            avg_latency_o     <= '0;
            violation_count_o <= '0;
            p95_latency_o     <= '0;
            p99_latency_o     <= '0;
            // hold the result back until selection and division finish
            out_valid_q       <= !div_start;
            unique case (item_i.kind)
              lsm_pkg::KIND_RECORD: begin
                if (count_q != '1) begin
                  count_q <= count_q + 32'd1;
                end
                sum_q <= sum_q + 64'(item_i.latency);
                if (item_i.latency > max_q) begin
                  max_q <= item_i.latency;
                end
                if (item_i.latency < min_q) begin
                  min_q <= item_i.latency;
                end
                if (fill_q < FW'(lsm_pkg::Window)) begin
                  fill_q <= fill_q + FW'(1);
                end else if (oldest_q == IW'(lsm_pkg::Window - 1)) begin
                  oldest_q <= '0;
                end else begin
                  oldest_q <= oldest_q + IW'(1);
                end
                if (item_i.latency > thr_q) begin
                  if (viol_q != '1) begin
                    viol_q <= viol_q + 32'd1;
                  end
                end
              end
              lsm_pkg::KIND_REPORT: begin
                if (count_q != '0) begin
                  k95_q   <= lsm_pkg::pct_index(fill_q, lsm_pkg::PCT_95);
                  k99_q   <= lsm_pkg::pct_index(fill_q, lsm_pkg::PCT_99);
                  cand_q  <= '0;
                  f95_q   <= 1'b0;
                  f99_q   <= 1'b0;
                  state_q <= ST_CAND;
                end
              end
              lsm_pkg::KIND_CLEAR: begin
                count_q  <= '0;
                sum_q    <= '0;
                max_q    <= '0;
                min_q    <= '1;
                viol_q   <= '0;
                fill_q   <= '0;
                oldest_q <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_CAND: begin
          state_q <= ST_CLAT;
        end
        ST_CLAT: begin
          cand_val_q <= rdata;
          lt_q       <= '0;
          le_q       <= '0;
          scan_q     <= FW'(1);
          pend_q     <= 1'b1;
          state_q    <= ST_SCAN;
        end
        ST_SCAN: begin
          if (pend_q) begin
            if (rdata < cand_val_q) begin
              lt_q <= lt_q + FW'(1);
            end
            if (rdata <= cand_val_q) begin
              le_q <= le_q + FW'(1);
            end
          end
          if (scan_q < fill_q) begin
            scan_q <= scan_q + FW'(1);
            pend_q <= 1'b1;
          end else begin
            pend_q  <= 1'b0;
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          // candidate sits at sorted index k when lt <= k < le
          if (hit95) begin
            p95_q <= cand_val_q;
            f95_q <= 1'b1;
          end
          if (hit99) begin
            p99_q <= cand_val_q;
            f99_q <= 1'b1;
          end
          if ((f95_q || hit95) && (f99_q || hit99)) begin
            state_q <= ST_DIVW;
          end else begin
            cand_q  <= cand_q + FW'(1);
            state_q <= ST_CAND;
          end
        end
        ST_DIVW: begin
          if (div_done) begin
            sample_count_o    <= count_q;
            max_latency_o     <= max_q;
            min_latency_o     <= min_q;
            avg_latency_o     <= quotient;
            violation_count_o <= viol_q;
            p95_latency_o     <= p95_q;
            p99_latency_o     <= p99_q;
            out_valid_q       <= 1'b1;
            state_q           <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o.busy   = (state_q != ST_IDLE);
  assign status_o.fill   = fill_q;

endmodule

`default_nettype wire

/* rtl/latency_statistics_monitor.sv */
// ----------------------------------------------------------------------------
// Latency statistics monitor
// Running count, sum, extremes, violations and window percentiles of samples.
// ----------------------------------------------------------------------------
//
//  Channel   | Handshake            | Payload
//  ----------+----------------------+-----------------------------------------
//  command   | push / full          | command_i, latency_i
//  result    | empty / pop          | violation_o .. p99_latency_o
//  threshold | cfg_we_i             | cfg_wdata_i
//
//  Record, clear and unknown commands are executed as the back end takes them
//  from the queue. A report with n window samples scans the window once per
//  candidate value, up to n candidates, set by the single read port of the
//  window RAM; the average divider runs alongside, and the result is held back
//  until both selection and division finish. An empty report completes as the
//  back end takes it. Reset is asynchronous and needs no clearing pass. A result
//  waiting in the output register stalls only the back end; the two-entry
//  queue keeps taking commands until it is full.
//
`timescale 1ns / 1ps
`default_nettype none
`include "latency_statistics_monitor_defines.svh"

module latency_statistics_monitor (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  command_i,
  input  wire logic [31:0] latency_i,
  output logic             empty,
  input  wire logic        pop,
  output logic             violation_o,
  output logic             empty_res_o,
  output logic [31:0]      sample_count_o,
  output logic [31:0]      max_latency_o,
  output logic [31:0]      min_latency_o,
  output logic [31:0]      avg_latency_o,
  output logic [31:0]      violation_count_o,
  output logic [31:0]      p95_latency_o,
  output logic [31:0]      p99_latency_o,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i
);

  logic                  item_valid, item_take, out_valid;
  lsm_pkg::item_t        item;
  lsm_pkg::back_status_t bstat;

  // Front: accept and classify each transfer into the queue
  lsm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .command_i   (command_i),
    .latency_i   (latency_i),
    .item_valid_o(item_valid),
    .item_o      (item),
    .item_take_i (item_take)
  );

  // Back: execute commands and hold one result for transfer
  lsm_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .item_valid_i     (item_valid),
    .item_i           (item),
    .item_take_o      (item_take),
    .pop_i            (pop),
    .out_valid_o      (out_valid),
    .violation_o      (violation_o),
    .empty_res_o      (empty_res_o),
    .sample_count_o   (sample_count_o),
    .max_latency_o    (max_latency_o),
    .min_latency_o    (min_latency_o),
    .avg_latency_o    (avg_latency_o),
    .violation_count_o(violation_count_o),
    .p95_latency_o    (p95_latency_o),
    .p99_latency_o    (p99_latency_o),
    .status_o         (bstat)
  );

  assign empty = !out_valid;

  // No result may wait while a report is being built
  `LSM_ASSERT_IMP(a_busy_no_result, bstat.busy, empty, "result shown during report")
  // Window fill never exceeds the window depth
  `LSM_ASSERT_IMP(a_fill_bound, 1'b1, bstat.fill <= lsm_pkg::FillW'(lsm_pkg::Window), "fill overflow")
  // An empty report carries zeros
  `LSM_ASSERT_IMP(a_empty_zero, !empty && empty_res_o, sample_count_o == '0 && p95_latency_o == '0, "empty report")
  // Hold a waiting result until its transfer
  `LSM_ASSERT_NXT(a_result_hold, !empty && !pop, !empty, "result dropped before transfer")

endmodule

`default_nettype wire

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// Latency statistics monitor testbench
// Feeds records, reports, clears and unknown commands through the push/full
// queue under random idle gaps and pop stalls. Each transfer is checked
// against a statistics tracker kept beside the block. The threshold is
// rewritten at idle points.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam int StallLimit = 200000;

  typedef struct packed {
    logic        violation;
    logic        empty_res;
    logic [31:0] sample_count;
    logic [31:0] max_latency;
    logic [31:0] min_latency;
    logic [31:0] avg_latency;
    logic [31:0] violation_count;
    logic [31:0] p95_latency;
    logic [31:0] p99_latency;
  } stats_t;

  logic        clk_i, rst_ni;
  logic        push, full, empty, pop;
  logic [1:0]  command_i;
  logic [31:0] latency_i;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;
  stats_t      got;

  latency_statistics_monitor dut (
    .clk_i, .rst_ni, .push, .full, .command_i, .latency_i, .empty, .pop,
    .violation_o(got.violation), .empty_res_o(got.empty_res),
    .sample_count_o(got.sample_count), .max_latency_o(got.max_latency),
    .min_latency_o(got.min_latency), .avg_latency_o(got.avg_latency),
    .violation_count_o(got.violation_count), .p95_latency_o(got.p95_latency),
    .p99_latency_o(got.p99_latency), .cfg_we_i, .cfg_wdata_i
  );

  // Tracker state: mirrors what the block should hold
  logic [31:0] win [lsm_pkg::Window];
  int unsigned fill, oldest;
  logic [63:0] lat_sum;
  logic [31:0] n_samples, lat_max, lat_min, n_viol, threshold;

  stats_t      pending_stats[$];
  int unsigned mismatches;
  int unsigned stall_cycles;
  bit          quiet;   // suppress idle gaps on both sides

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Random idle length: mostly none or short, a few long
  function automatic int unsigned gap_len();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void clear_stats();
    fill = 0;
    oldest = 0;
    lat_sum = '0;
    n_samples = '0;
    lat_max = '0;
    lat_min = '1;
    n_viol = '0;
  endfunction

  // Apply one command to the tracker and return the result it should give
  function automatic stats_t apply_command(logic [1:0] cmd, logic [31:0] lat);
    stats_t      r;
    logic [31:0] sorted[$];
    logic [63:0] avg;
    r = '0;
    case (cmd)
      lsm_pkg::CMD_RECORD: begin
        if (n_samples != '1) n_samples++;
        lat_sum += 64'(lat);
        if (lat > lat_max) lat_max = lat;
        if (lat < lat_min) lat_min = lat;
        if (fill < lsm_pkg::Window) begin
          win[(oldest + fill) % lsm_pkg::Window] = lat;
          fill++;
        end else begin
          win[oldest] = lat;
          oldest = (oldest + 1) % lsm_pkg::Window;
        end
        if (lat > threshold) begin
          if (n_viol != '1) n_viol++;
          r.violation = 1'b1;
        end
      end
      lsm_pkg::CMD_REPORT: begin
        if (n_samples == 0 || fill == 0) begin
          r.empty_res = 1'b1;
        end else begin
          avg = lat_sum / 64'(n_samples);
          if (avg > 64'hFFFF_FFFF) avg = 64'hFFFF_FFFF;
          for (int i = 0; i < fill; i++) sorted = {sorted, win[i]};
          sorted.sort();
          r.sample_count    = n_samples;
          r.max_latency     = lat_max;
          r.min_latency     = lat_min;
          r.avg_latency     = avg[31:0];
          r.violation_count = n_viol;
          r.p95_latency     = sorted[(fill * 95) / 100];
          r.p99_latency     = sorted[(fill * 99) / 100];
        end
      end
      lsm_pkg::CMD_CLEAR: clear_stats();
      default: ;
    endcase
    return r;
  endfunction

  // Send one command; hold push until the transfer, then maybe idle
  task automatic send(logic [1:0] cmd, logic [31:0] lat);
    int unsigned g;
    push      <= 1'b1;
    command_i <= cmd;
    latency_i <= lat;
    do @(posedge clk_i); while (full);
    pending_stats = {pending_stats, apply_command(cmd, lat)};
    g = gap_len();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // Drop push, wait for all results, then let the back end settle
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [31:0] v);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    threshold    = v;
  endtask

  function automatic logic [31:0] rand_latency();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : 32'd0;
      2: return threshold + 32'($urandom_range(0, 2)) - 32'd1;
      default: return $urandom_range(0, 10000);
    endcase
  endfunction

  task automatic test_directed();
    send(lsm_pkg::CMD_REPORT, 32'hFFFF_FFFF);   // report on an empty monitor
    send(lsm_pkg::CMD_RECORD, 32'd0);
    send(lsm_pkg::CMD_RECORD, 32'hFFFF_FFFF);
    send(lsm_pkg::CMD_RECORD, 32'd5000);        // at threshold: no violation
    send(lsm_pkg::CMD_RECORD, 32'd5001);
    send(CMD_UNKNOWN, 32'hA5A5_A5A5);           // no state change
    send(lsm_pkg::CMD_REPORT, 32'd0);
    send(lsm_pkg::CMD_CLEAR, 32'h1234_5678);
    send(lsm_pkg::CMD_REPORT, 32'd0);
    send(lsm_pkg::CMD_RECORD, 32'd7);
    send(lsm_pkg::CMD_REPORT, 32'd0);           // single-sample window
    write_threshold(32'd0);
    send(lsm_pkg::CMD_RECORD, 32'd0);
    send(lsm_pkg::CMD_RECORD, 32'd1);
    send(lsm_pkg::CMD_CLEAR, 32'd0);            // threshold survives the clear
    send(lsm_pkg::CMD_RECORD, 32'd1);
    write_threshold(32'hFFFF_FFFF);
    send(lsm_pkg::CMD_RECORD, 32'hFFFF_FFFF);
    send(lsm_pkg::CMD_REPORT, 32'd0);
    send(lsm_pkg::CMD_CLEAR, 32'd0);
  endtask

  // Wrap the window past full over several record bursts, reporting after each
  task automatic test_full_window();
    write_threshold($urandom_range(0, 10000));
    send(lsm_pkg::CMD_CLEAR, $urandom());
    for (int b = 0; b < 2; b++) begin
      repeat ($urandom_range(lsm_pkg::Window + 1, 2 * lsm_pkg::Window + 40))
        send(lsm_pkg::CMD_RECORD, rand_latency());
      send(lsm_pkg::CMD_REPORT, $urandom());
    end
    repeat (lsm_pkg::Window - 1) send(lsm_pkg::CMD_RECORD, rand_latency());
    send(lsm_pkg::CMD_REPORT, $urandom());
  endtask

  // Short record bursts closed by a report; keeps report scans cheap
  task automatic test_short_bursts(int unsigned n_bursts);
    for (int b = 0; b < n_bursts; b++) begin
      if (b % 20 == 0) begin
        case ($urandom_range(0, 3))
          0: write_threshold(32'd0);
          1: write_threshold(32'hFFFF_FFFF);
          default: write_threshold($urandom_range(0, 10000));
        endcase
        quiet = ($urandom_range(0, 3) == 0);
      end
      send(lsm_pkg::CMD_CLEAR, $urandom());
      repeat ($urandom_range(1, 30)) begin
        case ($urandom_range(0, 19))
          0: send(CMD_UNKNOWN, $urandom());
          1: send(lsm_pkg::CMD_REPORT, $urandom());
          default: send(lsm_pkg::CMD_RECORD, rand_latency());
        endcase
      end
      send(lsm_pkg::CMD_REPORT, $urandom());
    end
    quiet = 1'b0;
  endtask

  // Check each result transfer, drive pop and guard against a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        if (pending_stats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          if (got !== pending_stats[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch\n  exp %h\n  got %h", pending_stats[0], got);
          end
          void'(pending_stats.pop_front());
        end
      end
      if ((pop && !empty) || (push && !full)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
    pop <= quiet ? 1'b1 : (gap_len() == 0);
  end

  initial begin
    rst_ni = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    command_i = lsm_pkg::CMD_RECORD;
    latency_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    mismatches = 0;
    stall_cycles = 0;
    quiet = 1'b0;
    threshold = 32'd5000;
    clear_stats();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_full_window();
    test_short_bursts(70);
    wait_idle();
    repeat (50) @(posedge clk_i);

    if (mismatches == 0 && pending_stats.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* latency_statistics_monitor.f */
+incdir+rtl
rtl/lsm_pkg.sv
rtl/lsm_ram.sv
rtl/lsm_div.sv
rtl/lsm_front.sv
rtl/lsm_back.sv
rtl/latency_statistics_monitor.sv
bench/tb.sv
